// ----- rtl/core/gbr_pkg.sv -----
package gbr_pkg;

   // fixed field widths
   localparam int GBR_DATA_W = 32;
   localparam int GBR_CFG_W  = 5;
   localparam logic [GBR_CFG_W-1:0] GBR_CFG_RESET = 5'd4;

   // sized for the largest supported group (64 entries)
   localparam int GBR_CNT_W = 7;
   localparam int GBR_IDX_W = 6;

   // one closed group handed from front to back
   typedef struct packed {
      logic                 bank;
      logic [GBR_CNT_W-1:0] count;
      logic                 reverse;
      logic                 last;
   } gbr_desc_type;

   // group buffer write from the front
   typedef struct packed {
      logic                  en;
      logic                  bank;
      logic [GBR_IDX_W-1:0]  idx;
      logic [GBR_DATA_W-1:0] data;
   } gbr_wr_type;

   // bank handed back by the back end once fully read
   typedef struct packed {
      logic valid;
      logic bank;
   } gbr_rel_type;

endpackage

// ----- rtl/core/gbr_ifs.sv -----
interface gbr_req_if import gbr_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [GBR_DATA_W-1:0] value;
   logic                         end_of_list;

   modport source (output valid, output value, output end_of_list, input ready);
   modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

interface gbr_rsp_if import gbr_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [GBR_DATA_W-1:0] out_value;
   logic                         out_last;

   modport source (output valid, output out_value, output out_last, input ready);
   modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

// ----- rtl/core/gbr_front.sv -----
module gbr_front import gbr_pkg::*; #(
   parameter int MAX_GROUP = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [GBR_CFG_W-1:0] csr_wdata,
   gbr_req_if.sink              req_if,
   input  gbr_rel_type          rel,
   input  logic                 q_full,
   output logic                 push,
   output gbr_desc_type         push_desc,
   output gbr_wr_type           wr
);

   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

   logic [GBR_CFG_W-1:0] group_size_ff, group_size_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 wr_bank_ff, wr_bank_in;
   logic [1:0]           busy_ff, busy_in;
   logic [CNT_W-1:0]     k_eff;
   logic [CNT_W-1:0]     n_held;
   logic                 accept;
   logic                 full_group;
   logic                 close;

   // effective group size, clamped to 1..MAX_GROUP
   always_comb begin
      if (group_size_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (int'(group_size_ff) > MAX_GROUP) begin
         k_eff = CNT_W'(MAX_GROUP);
      end else begin
         k_eff = CNT_W'(group_size_ff);
      end
   end

   // item classification
   assign req_if.ready = !busy_ff[wr_bank_ff] && !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign n_held       = fill_ff + CNT_W'(1);
   assign full_group   = n_held >= k_eff;
   assign close        = full_group || req_if.end_of_list;

   // group buffer write
   assign wr.en   = accept;
   assign wr.bank = wr_bank_ff;
   assign wr.idx  = GBR_IDX_W'(fill_ff[IDX_W-1:0]);
   assign wr.data = req_if.value;

   // descriptor of a closed group
   assign push              = accept && close;
   assign push_desc.bank    = wr_bank_ff;
   assign push_desc.count   = GBR_CNT_W'(n_held);
   assign push_desc.reverse = full_group;
   assign push_desc.last    = req_if.end_of_list;

   // next state
   always_comb begin
      group_size_in = csr_we ? csr_wdata : group_size_ff;
      fill_in       = fill_ff;
      wr_bank_in    = wr_bank_ff;
      busy_in       = busy_ff;
      if (accept) begin
         fill_in = close ? '0 : n_held;
      end
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (push) begin
         busy_in[wr_bank_ff] = 1'b1;
         wr_bank_in          = !wr_bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= GBR_CFG_RESET;
         fill_ff       <= '0;
         wr_bank_ff    <= 1'b0;
         busy_ff       <= '0;
      end else begin
         group_size_ff <= group_size_in;
         fill_ff       <= fill_in;
         wr_bank_ff    <= wr_bank_in;
         busy_ff       <= busy_in;
      end
   end

   // only a bank that holds a queued group is handed back
   a_rel_busy: assert property (@(posedge clock) disable iff (reset)
      rel.valid |-> busy_ff[rel.bank])
      else $error("bank released while not in use");

   // the bank being filled is never one still awaiting readout
   a_fill_free: assert property (@(posedge clock) disable iff (reset)
      accept |-> !busy_ff[wr_bank_ff])
      else $error("write into a bank still being drained");

endmodule

// ----- rtl/core/gbr_queue.sv -----
module gbr_queue import gbr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  gbr_desc_type push_desc,
   input  logic         pop,
   output logic         full,
   output logic         head_valid,
   output gbr_desc_type head
);

   gbr_desc_type entry_ff [2];
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign full       = cnt_ff == 2'd2;
   assign head_valid = cnt_ff != 2'd0;
   assign head       = entry_ff[rptr_ff];

   // pointer and count update
   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = pop ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // descriptor storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("descriptor queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("descriptor queue underflow");

endmodule

// ----- rtl/core/gbr_back.sv -----
module gbr_back import gbr_pkg::*; #(
   parameter int MAX_GROUP = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  gbr_wr_type   wr,
   input  logic         q_valid,
   input  gbr_desc_type q_desc,
   output logic         pop,
   output gbr_rel_type  rel,
   gbr_rsp_if.source    rsp_if
);

   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int DEPTH = 2 * (1 << IDX_W);

   logic [GBR_DATA_W-1:0] mem [DEPTH];
   logic [GBR_DATA_W-1:0] rd_ff;
   logic                  last_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      count;
   logic [CNT_W-1:0]      last_idx;
   logic [CNT_W-1:0]      pos;
   logic [IDX_W:0]        rd_addr;
   logic                  issue;
   logic                  final_rd;

   // read sequencing over the head group
   assign count    = q_desc.count[CNT_W-1:0];
   assign last_idx = count - CNT_W'(1);
   assign final_rd = idx_ff == last_idx;
   assign pos      = q_desc.reverse ? (last_idx - idx_ff) : idx_ff;
   assign rd_addr  = {q_desc.bank, pos[IDX_W-1:0]};
   assign issue    = q_valid && (!out_valid_ff || rsp_if.ready);

   assign pop       = issue && final_rd;
   assign rel.valid = pop;
   assign rel.bank  = q_desc.bank;

   // result register doubles as the memory read register
   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.out_value = rd_ff;
   assign rsp_if.out_last  = last_ff;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (issue) begin
         out_valid_in = 1'b1;
         idx_in       = final_rd ? '0 : idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // double-banked group buffer
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr.bank, wr.idx[IDX_W-1:0]}] <= wr.data;
      end
      if (issue) begin
         rd_ff   <= mem[rd_addr];
         last_ff <= q_desc.last && final_rd;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> (idx_ff < count))
      else $error("read index beyond group length");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> (count != '0))
      else $error("empty group queued");

endmodule

// ----- rtl/core/stream_group_reverser.sv -----
// stream_group_reverser
// req_if carries one signed 32-bit value per item plus end_of_list on the
// final value of a list. Values are collected until group_size of them are
// held; that group then leaves on rsp_if in reverse order. A shorter group
// closed by end_of_list leaves in arrival order. out_last marks the final
// item emitted for a list.
// csr_we/csr_wdata write group_size (reset 4, 0 acts as 1, values above
// MAX_GROUP act as MAX_GROUP); write it only while no list is in flight.
// The first result of a group is registered: the item closing the group
// enters the descriptor queue, then readout loads it into the result
// register; the rest follow one per cycle while rsp_if.ready is high.
// Throughput: one item per cycle on each side. The group buffer has two
// banks, so one group fills while the previous one drains; req_if.ready
// drops only while both banks hold groups not yet fully read out.
// When rsp_if.ready is low the result register holds its item, readout
// pauses, and once both banks are full the input stalls as well.
// Reset (synchronous) empties the buffer and queue; no clearing pass.
module stream_group_reverser import gbr_pkg::*; #(
   parameter int MAX_GROUP = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [GBR_CFG_W-1:0] csr_wdata,
   gbr_req_if.sink              req_if,
   gbr_rsp_if.source            rsp_if
);

   gbr_desc_type push_desc;
   gbr_desc_type head;
   gbr_wr_type   wr;
   gbr_rel_type  rel;
   logic         push;
   logic         pop;
   logic         q_full;
   logic         q_valid;

   // intake and grouping
   gbr_front #(.MAX_GROUP(MAX_GROUP)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rel       (rel),
      .q_full    (q_full),
      .push      (push),
      .push_desc (push_desc),
      .wr        (wr)
   );

   // closed groups waiting for readout
   gbr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (head)
   );

   // buffer readout
   gbr_back #(.MAX_GROUP(MAX_GROUP)) u_back (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .q_valid (q_valid),
      .q_desc  (head),
      .pop     (pop),
      .rel     (rel),
      .rsp_if  (rsp_if)
   );

endmodule
